// ----- rtl/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes for the reverse-Polish integer stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    // default stack size
    localparam int unsigned STACK_DEPTH_DEF = 64;

    // token codes
    localparam logic [3:0] OP_PUSH   = 4'd0;
    localparam logic [3:0] OP_ADD    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_DIV    = 4'd4;
    localparam logic [3:0] OP_POW    = 4'd5;
    localparam logic [3:0] OP_SQRT   = 4'd6;
    localparam logic [3:0] OP_LOG    = 4'd7;
    localparam logic [3:0] OP_SELECT = 4'd8;
    localparam logic [3:0] OP_END    = 4'd9;

    // input beat
    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] push_value;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [31:0] final_value;
        logic               ok;
    } t_out_beat;

    // request to the arithmetic unit
    typedef struct packed {
        logic        start;
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_alu_req;

    // response from the arithmetic unit
    typedef struct packed {
        logic        done;
        logic        err;
        logic [31:0] value;
    } t_alu_rsp;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CAP,
        S_START,
        S_WAIT,
        S_END_RD,
        S_END_OUT
    } t_ctl_state;

    // arithmetic unit states
    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_POW_SQ,
        A_POW_MUL,
        A_SQRT,
        A_LOG,
        A_DONE
    } t_alu_state;

endpackage

// ----- rtl/rpn_alu.sv -----
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative arithmetic unit around one shared 32x32 multiplier and one divide
// trial subtractor: divide, power, square root and logarithm take many steps.
// ----------------------------------------------------------------------------
module rpn_alu
    import rpn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    t_alu_state r_state, n_state;
    logic [31:0] r_acc, n_acc;   // product, root, quotient or count
    logic [31:0] r_rem, n_rem;   // remainder or log power
    logic [31:0] r_x, n_x;       // first operand
    logic [31:0] r_y, n_y;       // second operand (magnitude for divide)
    logic [4:0]  r_step, n_step;
    logic        r_neg, n_neg;
    logic        r_err, n_err;

    // shared multiplier
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    // divide step and root trial
    logic [32:0] div_trial;
    logic [31:0] sqrt_t;
    assign div_trial = {r_rem, r_acc[31]} - {1'b0, r_y};
    assign sqrt_t    = r_acc | (32'd1 << r_step);

    // multiplier operand selection
    always_comb begin
        mul_x = i_req.a;
        mul_y = i_req.b;
        unique case (r_state)
            A_POW_SQ:  begin mul_x = r_acc; mul_y = r_acc; end
            A_POW_MUL: begin mul_x = r_acc; mul_y = r_x;   end
            A_SQRT:    begin mul_x = sqrt_t; mul_y = sqrt_t; end
            A_LOG:     begin mul_x = r_rem; mul_y = r_y;   end
            default:   begin mul_x = i_req.a; mul_y = i_req.b; end
        endcase
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_x     = r_x;
        n_y     = r_y;
        n_step  = r_step;
        n_neg   = r_neg;
        n_err   = r_err;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_err   = 1'b0;
                    n_state = A_DONE;
                    n_x     = i_req.a;
                    n_y     = i_req.b;
                    n_step  = 5'd31;
                    case (i_req.op)
                        OP_ADD: n_acc = i_req.a + i_req.b;
                        OP_SUB: n_acc = i_req.a - i_req.b;
                        OP_MUL: n_acc = mul_p[31:0];
                        OP_DIV: begin
                            if (i_req.b == 32'd0 ||
                                (i_req.a == 32'h8000_0000 && i_req.b == 32'hFFFF_FFFF)) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc   = i_req.a[31] ? -i_req.a : i_req.a;
                                n_y     = i_req.b[31] ? -i_req.b : i_req.b;
                                n_rem   = 32'd0;
                                n_neg   = i_req.a[31] ^ i_req.b[31];
                                n_state = A_DIV;
                            end
                        end
                        OP_POW: begin
                            if (i_req.b[31]) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc   = 32'd1;
                                n_state = A_POW_SQ;
                            end
                        end
                        OP_SQRT: begin
                            if (i_req.a[31]) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc   = 32'd0;
                                n_step  = 5'd15;
                                n_state = A_SQRT;
                            end
                        end
                        OP_LOG: begin
                            if ($signed(i_req.b) <= 32'sd1) begin
                                n_err = 1'b1;
                            end else begin
                                n_acc   = 32'd0;
                                n_rem   = 32'd1;
                                n_state = A_LOG;
                            end
                        end
                        default: n_acc = (i_req.a == 32'd0) ? i_req.c : i_req.b;
                    endcase
                end
            end
            A_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (!div_trial[32]) begin
                    n_rem = div_trial[31:0];
                    n_acc = {r_acc[30:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_acc[31]};
                    n_acc = {r_acc[30:0], 1'b0};
                end
                n_step = r_step - 5'd1;
                if (r_step == 5'd0) begin
                    if (r_neg) begin
                        n_acc = -n_acc;
                    end
                    n_state = A_DONE;
                end
            end
            A_POW_SQ: begin
                n_acc = mul_p[31:0];
                if (r_y[r_step]) begin
                    n_state = A_POW_MUL;
                end else if (r_step == 5'd0) begin
                    n_state = A_DONE;
                end else begin
                    n_step = r_step - 5'd1;
                end
            end
            A_POW_MUL: begin
                n_acc = mul_p[31:0];
                if (r_step == 5'd0) begin
                    n_state = A_DONE;
                end else begin
                    n_step  = r_step - 5'd1;
                    n_state = A_POW_SQ;
                end
            end
            A_SQRT: begin
                if (mul_p <= {32'd0, r_x}) begin
                    n_acc = sqrt_t;
                end
                n_step = r_step - 5'd1;
                if (r_step == 5'd0) begin
                    n_state = A_DONE;
                end
            end
            A_LOG: begin
                // grow the power of the base while it stays within x
                if ($signed(mul_p) <= $signed({{32{r_x[31]}}, r_x})) begin
                    n_rem = mul_p[31:0];
                    n_acc = r_acc + 32'd1;
                end else begin
                    n_state = A_DONE;
                end
            end
            A_DONE: n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    // response
    always_comb begin
        o_rsp.done  = (r_state == A_DONE);
        o_rsp.err   = r_err;
        o_rsp.value = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_x    <= n_x;
        r_y    <= n_y;
        r_step <= n_step;
        r_neg  <= n_neg;
    end

endmodule

// ----- rtl/rpn_integer_stack_calculator.sv -----
// push, ignored and error tokens are handled in the idle state; stack ops read
// 1 to 3 operands from the stack memory (S_RD, S_CAP each), then run in the
// shared unit (S_START, S_WAIT). end token: S_END_RD, then S_END_OUT forms an
// output beat, which may wait in the output register. one token at a time;
// reset clears count, error flag and sequencer, not the stack.
// ----------------------------------------------------------------------------
// rpn_integer_stack_calculator
// Reverse-Polish integer calculator with an operand stack in memory and an
// iterative arithmetic unit.
// ----------------------------------------------------------------------------
module rpn_integer_stack_calculator
    import rpn_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    t_ctl_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_err, n_err;
    logic [1:0]    r_k, n_k;
    logic [1:0]    r_need, n_need;
    logic [3:0]    r_op, n_op;
    logic [31:0]   r_opa, n_opa, r_opb, n_opb, r_opc, n_opc;
    logic          r_end_ok, n_end_ok;
    logic          r_out_valid, n_out_valid;
    t_out_beat     r_out_beat, n_out_beat;

    // stack memory
    logic [31:0]   r_mem [STACK_DEPTH];
    logic [31:0]   r_rd_data;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic       in_beat;
    logic [1:0] in_need;
    logic [CW-1:0] top_idx;

    assign in_beat = i_in_valid && o_in_ready;
    assign in_need = (i_in_beat.operation == OP_SQRT)   ? 2'd1 :
                     (i_in_beat.operation == OP_SELECT) ? 2'd3 : 2'd2;
    assign top_idx = r_count - CW'(1) - CW'(r_k);

    rpn_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (i_in_beat.operation == OP_END) begin
                        n_state = S_END_RD;
                    end else if (!r_err && i_in_beat.operation != OP_PUSH &&
                                 i_in_beat.operation < OP_END &&
                                 r_count >= CW'(in_need)) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:      n_state = S_CAP;
            S_CAP:     n_state = (r_k == r_need - 2'd1) ? S_START : S_RD;
            S_START:   n_state = S_WAIT;
            S_WAIT:    n_state = alu_rsp.done ? S_IDLE : S_WAIT;
            S_END_RD:  n_state = S_END_OUT;
            S_END_OUT: n_state = (!r_out_valid || i_out_ready) ? S_IDLE : S_END_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_err       = r_err;
        n_k         = r_k;
        n_need      = r_need;
        n_op        = r_op;
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_opc       = r_opc;
        n_end_ok    = r_end_ok;
        n_out_beat  = r_out_beat;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = top_idx[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = i_in_beat.push_value;
        alu_req       = '0;
        alu_req.op    = r_op;
        alu_req.a     = r_opa;
        alu_req.b     = r_opb;
        alu_req.c     = r_opc;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (i_in_beat.operation == OP_END) begin
                        n_end_ok = !r_err && (r_count == CW'(1));
                    end else if (!r_err && i_in_beat.operation < OP_END) begin
                        if (i_in_beat.operation == OP_PUSH) begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                n_err = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end else if (r_count < CW'(in_need)) begin
                            n_err = 1'b1;
                        end else begin
                            n_k    = 2'd0;
                            n_need = in_need;
                            n_op   = i_in_beat.operation;
                        end
                    end
                end
            end
            S_RD: rd_en = 1'b1;
            S_CAP: begin
                case (r_k)
                    2'd0:    n_opa = r_rd_data;
                    2'd1:    n_opb = r_rd_data;
                    default: n_opc = r_rd_data;
                endcase
                n_k = r_k + 2'd1;
            end
            S_START: begin
                alu_req.start = 1'b1;
                n_count       = r_count - CW'(r_need);
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.err) begin
                        n_err = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = alu_rsp.value;
                        n_count = r_count + CW'(1);
                    end
                end
            end
            S_END_RD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_END_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out_beat.final_value = r_end_ok ? r_rd_data : 32'd0;
                    n_out_beat.ok          = r_end_ok;
                    n_count                = '0;
                    n_err                  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // stack memory port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_k        <= n_k;
        r_need     <= n_need;
        r_op       <= n_op;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_opc      <= n_opc;
        r_end_ok   <= n_end_ok;
        r_out_beat <= n_out_beat;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.ok) |-> (o_out_beat.final_value == 32'sd0))
        else $error("error beat carries a value");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == S_WAIT))
        else $error("unit finished outside wait");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END_OUT && (!r_out_valid || i_out_ready)) |=>
            (r_count == '0 && !r_err && o_out_valid))
        else $error("end beat did not clear the stack");

endmodule

// ----- tb/tb_rpn_integer_stack_calculator.sv -----
// ----------------------------------------------------------------------------
// tb_rpn_integer_stack_calculator
// Drives token beats into the reverse-Polish calculator under random sender
// gaps and receiver stalls. A local model of the stack predicts each end-token
// beat, and a checker compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rpn_integer_stack_calculator;

    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int unsigned DEPTH = STACK_DEPTH_DEF;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_beat;

    // predictor state
    logic [31:0] calc_stack [DEPTH];
    int unsigned calc_depth;
    bit          calc_err;
    t_out_beat   expected_results [$];

    int unsigned mismatch_count;
    bit          hold_off;
    bit          burst_on;
    int unsigned burst_left;

    rpn_integer_stack_calculator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [31:0] power_wrap(logic [31:0] base, logic [31:0] ex);
        logic [31:0] p;
        p = 32'd1;
        for (int i = 31; i >= 0; i--) begin
            p = p * p;
            if (ex[i]) p = p * base;
        end
        return p;
    endfunction

    function automatic logic [31:0] root_floor(longint n);
        longint r;
        longint t;
        r = 0;
        for (int i = 15; i >= 0; i--) begin
            t = r | (longint'(1) << i);
            if (t * t <= n) r = t;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] log_floor(longint base, longint x);
        int unsigned n;
        n = 0;
        while (x >= base) begin
            x = x / base;
            n++;
        end
        return n;
    endfunction

    function automatic void stack_push(logic [31:0] v);
        if (calc_depth >= DEPTH) begin
            calc_err = 1'b1;
        end else begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endfunction

    // work out the effect of one accepted token
    function automatic void calc_token(t_in_beat t);
        int unsigned need;
        logic [31:0] a, b, c, r;
        longint sa, sb;
        a = '0; b = '0; c = '0; r = '0;
        if (t.operation == OP_END) begin
            if (!calc_err && calc_depth == 1) expected_results.push_back({calc_stack[0], 1'b1});
            else expected_results.push_back({32'd0, 1'b0});
            calc_depth = 0;
            calc_err = 1'b0;
            return;
        end
        if (t.operation > OP_END || calc_err) return;
        if (t.operation == OP_PUSH) begin
            stack_push(t.push_value);
            return;
        end
        need = (t.operation == OP_SQRT) ? 1 : (t.operation == OP_SELECT) ? 3 : 2;
        if (calc_depth < need) begin
            calc_err = 1'b1;
            return;
        end
        calc_depth--; a = calc_stack[calc_depth];
        if (need >= 2) begin calc_depth--; b = calc_stack[calc_depth]; end
        if (need >= 3) begin calc_depth--; c = calc_stack[calc_depth]; end
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        case (t.operation)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: begin
                if (sb == 0 || (sa == -64'sd2147483648 && sb == -64'sd1)) begin
                    calc_err = 1'b1;
                    return;
                end
                r = 32'(sa / sb);
            end
            OP_POW: begin
                if (sb < 0) begin calc_err = 1'b1; return; end
                r = power_wrap(a, b);
            end
            OP_SQRT: begin
                if (sa < 0) begin calc_err = 1'b1; return; end
                r = root_floor(sa);
            end
            OP_LOG: begin
                if (sb <= 1) begin calc_err = 1'b1; return; end
                r = log_floor(sb, sa);
            end
            default: r = (a == 0) ? c : b;
        endcase
        stack_push(r);
    endfunction

    // send one token beat with bursty gaps
    task automatic send_token(logic [3:0] op, logic [31:0] v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            burst_on = $urandom_range(0, 3) != 0;
            if (burst_on) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_beat  <= '{operation: op, push_value: v};
        do @(posedge clk); while (!in_ready);
        calc_token('{operation: op, push_value: v});
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return -$urandom_range(0, 20);
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // receiver stall pattern, with one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end else begin
                out_ready <= $urandom_range(0, 2) != 0;
            end
        end
    end

    // output beat checker
    initial begin
        t_out_beat want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) $display("unexpected beat %p", out_beat);
                end else begin
                    want = expected_results.pop_front();
                    if (out_beat.final_value !== want.final_value || out_beat.ok !== want.ok) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %0d/%0b got %0d/%0b",
                                     want.final_value, want.ok,
                                     out_beat.final_value, out_beat.ok);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        // extremes of push and arithmetic wrap
        send_token(OP_PUSH, 32'h7fff_ffff); send_token(OP_PUSH, 32'd1);
        send_token(OP_ADD, 0); send_token(OP_END, 0);
        send_token(OP_PUSH, 32'd3); send_token(OP_PUSH, 32'd10);
        send_token(OP_SUB, 0); send_token(OP_PUSH, -32'sd4);
        send_token(OP_MUL, 0); send_token(OP_END, 0);
        // divide by zero, divide overflow
        send_token(OP_PUSH, 0); send_token(OP_PUSH, 7); send_token(OP_DIV, 0);
        send_token(OP_PUSH, 1); send_token(OP_END, 0);
        send_token(OP_PUSH, -1); send_token(OP_PUSH, 32'h8000_0000);
        send_token(OP_DIV, 0); send_token(OP_END, 0);
        // empty end, unused code, underflow
        send_token(OP_END, 0); send_token(4'd15, 32'hffff_ffff);
        send_token(OP_SQRT, 0); send_token(OP_END, 0);
        send_token(OP_PUSH, 32'h7fff_ffff); send_token(OP_SQRT, 0);
        send_token(OP_END, 0);
    endtask

    task automatic test_special_cases();
        send_token(OP_PUSH, -1); send_token(OP_PUSH, 2); send_token(OP_POW, 0);
        send_token(OP_END, 0);
        send_token(OP_PUSH, 31); send_token(OP_PUSH, 3); send_token(OP_POW, 0);
        send_token(OP_END, 0);
        send_token(OP_PUSH, -5); send_token(OP_SQRT, 0); send_token(OP_END, 0);
        send_token(OP_PUSH, 1); send_token(OP_PUSH, 100); send_token(OP_LOG, 0);
        send_token(OP_END, 0);
        send_token(OP_PUSH, 10); send_token(OP_PUSH, 32'h7fff_ffff);
        send_token(OP_LOG, 0); send_token(OP_END, 0);
        send_token(OP_PUSH, 9); send_token(OP_PUSH, 8); send_token(OP_PUSH, 0);
        send_token(OP_SELECT, 0); send_token(OP_END, 0);
        send_token(OP_PUSH, 9); send_token(OP_PUSH, 8); send_token(OP_PUSH, 1);
        send_token(OP_SELECT, 0); send_token(OP_PUSH, 4); send_token(OP_END, 0);
        // stack overflow
        for (int i = 0; i <= DEPTH; i++) send_token(OP_PUSH, i);
        send_token(OP_END, 0);
        // full stack with no overflow
        for (int i = 0; i < DEPTH; i++) send_token(OP_PUSH, i);
        for (int i = 1; i < DEPTH; i++) send_token(OP_ADD, 0);
        send_token(OP_END, 0);
    endtask

    // mostly well-formed expressions with random content
    task automatic test_random(int unsigned n_tokens);
        int unsigned sent;
        int unsigned depth;
        logic [3:0] op;
        sent = 0;
        while (sent < n_tokens) begin
            depth = 0;
            repeat ($urandom_range(1, 12)) begin
                if (depth < 3 || $urandom_range(0, 2) == 0) begin
                    send_token(OP_PUSH, rand_value());
                    depth++;
                end else begin
                    op = 4'($urandom_range(OP_ADD, OP_SELECT));
                    if ($urandom_range(0, 9) == 0) op = 4'($urandom_range(10, 15));
                    send_token(op, $urandom);
                    if (op <= OP_SELECT)
                        depth = depth - ((op == OP_SQRT) ? 0 : (op == OP_SELECT) ? 2 : 1);
                end
                sent++;
            end
            if ($urandom_range(0, 9) == 0) send_token(4'($urandom_range(0, 15)), $urandom);
            send_token(OP_END, 0);
            sent++;
        end
    endtask

    // receiver held off while tokens keep coming, then sender waits for all
    task automatic test_back_pressure();
        hold_off = 1'b1;
        repeat (30) begin
            send_token(OP_PUSH, 2);
            send_token(OP_END, 0);
        end
        drain_results();
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_beat    = '0;
        hold_off   = 1'b0;
        burst_left = 0;
        calc_depth = 0;
        calc_err   = 1'b0;
        mismatch_count = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_special_cases();
        test_back_pressure();
        test_random(1450);
        drain_results();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rpn_pkg.sv
rtl/rpn_alu.sv
rtl/rpn_integer_stack_calculator.sv
tb/tb_rpn_integer_stack_calculator.sv
